@@ rtl/core/psimd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package psimd_pkg;

  // Lane geometry
  localparam int LANE_W        = 8;
  localparam int MAX_LANES     = 16;
  localparam int HALF_LANES    = MAX_LANES / 2;
  localparam int HALF_W        = HALF_LANES * LANE_W;
  localparam int VEC_W         = MAX_LANES * LANE_W;
  localparam int LANES_DEFAULT = 16;

  localparam int MODE_W  = 5;
  localparam int SHAMT_W = 4;

  typedef logic [LANE_W-1:0]  lane_t;
  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [SHAMT_W-1:0] shamt_t;

  // Largest shift count; anything outside 0..SHIFT_MAX acts as SHIFT_MAX
  localparam shamt_t SHIFT_MAX = shamt_t'(LANE_W);

  // Opcodes
  localparam mode_t OP_ADD    = 5'd0;
  localparam mode_t OP_SUB    = 5'd1;
  localparam mode_t OP_MUL    = 5'd2;
  localparam mode_t OP_ADDSAT = 5'd3;
  localparam mode_t OP_SUBSAT = 5'd4;
  localparam mode_t OP_MIN    = 5'd5;
  localparam mode_t OP_MAX    = 5'd6;
  localparam mode_t OP_LT     = 5'd7;
  localparam mode_t OP_LE     = 5'd8;
  localparam mode_t OP_EQ     = 5'd9;
  localparam mode_t OP_NE     = 5'd10;
  localparam mode_t OP_GT     = 5'd11;
  localparam mode_t OP_GE     = 5'd12;
  localparam mode_t OP_SHL    = 5'd13;
  localparam mode_t OP_SAR    = 5'd14;
  localparam mode_t OP_SELECT = 5'd15;
  localparam mode_t OP_NEG    = 5'd16;
  localparam mode_t OP_SPLAT  = 5'd17;

  // Controls shared by every lane of one beat
  typedef struct packed {
    mode_t  mode;
    shamt_t shamt;
    lane_t  splat;
  } lane_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/psimd_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module psimd_lane (
  input  psimd_pkg::lane_ctl_t ctl,
  input  psimd_pkg::lane_t     a,
  input  psimd_pkg::lane_t     b,
  input  psimd_pkg::lane_t     c,
  output psimd_pkg::lane_t     r
);
  import psimd_pkg::*;

  logic signed [LANE_W:0]     sum_ext;
  logic signed [LANE_W:0]     dif_ext;
  lane_t                      prod;
  logic                       lt;
  logic                       eq;
  lane_t                      sum_sat;
  lane_t                      dif_sat;

  // Shared arithmetic; multiply keeps only the low byte
  assign sum_ext = $signed({a[LANE_W-1], a}) + $signed({b[LANE_W-1], b});
  assign dif_ext = $signed({a[LANE_W-1], a}) - $signed({b[LANE_W-1], b});
  assign prod    = a * b;
  assign lt      = $signed(a) < $signed(b);
  assign eq      = a == b;

  // Clamp on overflow: top two bits of the extended result disagree
  assign sum_sat = (sum_ext[LANE_W] != sum_ext[LANE_W-1]) ?
                   (sum_ext[LANE_W] ? {1'b1, {(LANE_W-1){1'b0}}} : {1'b0, {(LANE_W-1){1'b1}}}) :
                   sum_ext[LANE_W-1:0];
  assign dif_sat = (dif_ext[LANE_W] != dif_ext[LANE_W-1]) ?
                   (dif_ext[LANE_W] ? {1'b1, {(LANE_W-1){1'b0}}} : {1'b0, {(LANE_W-1){1'b1}}}) :
                   dif_ext[LANE_W-1:0];

  // Opcode select
  always_comb begin
    unique case (ctl.mode)
      OP_ADD:    r = sum_ext[LANE_W-1:0];
      OP_SUB:    r = dif_ext[LANE_W-1:0];
      OP_MUL:    r = prod;
      OP_ADDSAT: r = sum_sat;
      OP_SUBSAT: r = dif_sat;
      OP_MIN:    r = lt ? a : b;
      OP_MAX:    r = (!lt && !eq) ? a : b;
      OP_LT:     r = {LANE_W{lt}};
      OP_LE:     r = {LANE_W{lt || eq}};
      OP_EQ:     r = {LANE_W{eq}};
      OP_NE:     r = {LANE_W{!eq}};
      OP_GT:     r = {LANE_W{!lt && !eq}};
      OP_GE:     r = {LANE_W{!lt}};
      OP_SHL:    r = a << ctl.shamt;
      OP_SAR:    r = lane_t'($signed(a) >>> ctl.shamt);
      OP_SELECT: r = (a & b) | (~a & c);
      OP_NEG:    r = ~a + lane_t'(1);
      OP_SPLAT:  r = ctl.splat;
      default:   r = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/packed_byte_simd_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: a start beat passes the input register and then the result register, which raises done.
// Throughput: one operation per cycle; busy is always low, so start may be high every cycle.
// Each result is shown for exactly one cycle with done; there is no back-pressure and the
// receiver must take it then.
// Reset: synchronous, active high; clears the valid pipeline only, data registers are not reset.

module packed_byte_simd_alu #(
  parameter int LANES = psimd_pkg::LANES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  psimd_pkg::mode_t                   mode,
  input  logic [psimd_pkg::HALF_W-1:0]       a_lo,
  input  logic [psimd_pkg::HALF_W-1:0]       a_hi,
  input  logic [psimd_pkg::HALF_W-1:0]       b_lo,
  input  logic [psimd_pkg::HALF_W-1:0]       b_hi,
  input  logic [psimd_pkg::HALF_W-1:0]       c_lo,
  input  logic [psimd_pkg::HALF_W-1:0]       c_hi,
  input  logic signed [psimd_pkg::LANE_W-1:0] scalar,
  output logic                               done,
  output logic [psimd_pkg::HALF_W-1:0]       result_lo,
  output logic [psimd_pkg::HALF_W-1:0]       result_hi
);
  import psimd_pkg::*;

  logic                 valid_s1;
  mode_t                mode_r;
  logic [VEC_W-1:0]     a_r;
  logic [VEC_W-1:0]     b_r;
  logic [VEC_W-1:0]     c_r;
  logic signed [LANE_W-1:0] scalar_r;
  lane_ctl_t            ctl;
  logic [VEC_W-1:0]     res_w;

  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
    end else begin
      valid_s1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r   <= mode;
      a_r      <= {a_hi, a_lo};
      b_r      <= {b_hi, b_lo};
      c_r      <= {c_hi, c_lo};
      scalar_r <= scalar;
    end
  end

  // Shift count: negative or above the lane width acts as the lane width
  always_comb begin
    ctl.mode  = mode_r;
    ctl.splat = scalar_r;
    if (scalar_r < 0 || scalar_r > $signed(LANE_W'(SHIFT_MAX))) begin
      ctl.shamt = SHIFT_MAX;
    end else begin
      ctl.shamt = shamt_t'(scalar_r);
    end
  end

  // Lane array; lanes past LANES read as zero
  for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
    if (i < LANES) begin : g_on
      psimd_lane u_lane (
        .ctl (ctl),
        .a   (a_r[i*LANE_W +: LANE_W]),
        .b   (b_r[i*LANE_W +: LANE_W]),
        .c   (c_r[i*LANE_W +: LANE_W]),
        .r   (res_w[i*LANE_W +: LANE_W])
      );
    end else begin : g_off
      assign res_w[i*LANE_W +: LANE_W] = '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_s1) begin
      result_lo <= res_w[HALF_W-1:0];
      result_hi <= res_w[VEC_W-1:HALF_W];
    end
  end

  // Every start beat yields exactly one done strobe, through the input and result registers
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    start |=> ##1 done)
    else $error("start beat not followed by done");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("done without a start beat");

  // Splat puts the scalar in lane 0
  a_splat: assert property (@(posedge clk) disable iff (rst)
    (valid_s1 && mode_r == OP_SPLAT) |=> result_lo[LANE_W-1:0] == $past(scalar_r))
    else $error("splat lane 0 mismatch");

  // Unused opcodes give an all-zero result
  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    (valid_s1 && mode_r > OP_SPLAT) |=> (result_lo == '0 && result_hi == '0))
    else $error("unused opcode result not zero");

endmodule

`default_nettype wire
